>>> rtl/vpmd_pkg.sv
// shared types and constants for the valve pid motor drive core
package vpmd_pkg;

    // default sizes
    localparam int ADC_BITS_DEF      = 10;
    localparam int INTEGRAL_BITS_DEF = 24;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CLOSE_POS = 3'd0,
        REG_OPEN_POS  = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_KI_TS     = 3'd3,
        REG_KD_OVER   = 3'd4
    } cfg_reg_t;

    // drive direction codes
    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    // result request layout
    localparam int M_TDATA_W = 32;

    // fixed-point constants, q8.8 degrees
    localparam int FULL_SCALE_Q = 23040;  // 90.0
    localparam int POS_LIMIT_Q  = 32512;  // 127.0
    localparam int DEADBAND_Q   = 128;    // 0.5
    localparam int RESET_Q      = 1024;   // 4.0
    localparam int OPEN_END_Q   = 22656;  // 88.5
    localparam int CLOSE_END_Q  = 386;    // 1.51

    // speed limit and duty scaling (x*255/100 as multiply by 2^21/100)
    localparam int SPEED_MAX  = 100;
    localparam int DUTY_RECIP = 20972;
    localparam int DUTY_SHIFT = 21;

endpackage

>>> rtl/valve_pid_motor_drive_core.sv
// valve pid motor drive: position mapping, pid step and drive output
// steps: latch request, map position (multiply, restoring divide), error, deadband check,
// p/i/d multiplies and sum, speed clamp, duty multiply, result load; the deadband skips the
// pid steps and a zero calibration span skips the divide. one item at a time; the next request
// is taken from the cycle after the result is loaded, which waits under output stalls.
// reset: synchronous active-low aresetn clears control, integral, last error and
// loads the register reset values; no clearing pass.
module valve_pid_motor_drive_core #(
    parameter int ADC_BITS      = vpmd_pkg::ADC_BITS_DEF,
    parameter int INTEGRAL_BITS = vpmd_pkg::INTEGRAL_BITS_DEF,
    localparam int S_TDATA_W    = ((ADC_BITS + 17 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [vpmd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vpmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pot_sample, setpoint, open_switch_hit, close_switch_hit, zero fill
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // result requests
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drive_direction, drive_duty, position_deg, zero fill
    output logic [vpmd_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int SPAN_W = ADC_BITS + 1;
    localparam int NUM_W  = ADC_BITS + 15;
    localparam int MB_W0  = (INTEGRAL_BITS > SPAN_W) ? INTEGRAL_BITS : SPAN_W;
    localparam int MB_W   = (MB_W0 > 17) ? MB_W0 : 17;
    localparam int PW     = 16 + MB_W;
    localparam int ACC_W  = PW + 2;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int IB     = INTEGRAL_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MPOS, ST_DIVSET, ST_DIV, ST_POS, ST_ERR, ST_CHK,
        ST_MP, ST_MI, ST_MD, ST_SUM, ST_SPD, ST_MDUTY, ST_FIN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic        [ADC_BITS-1:0] close_reg, open_reg;
    logic signed [15:0]         gain_p_reg, ki_ts_reg, kd_reg;

    // latched input request
    logic [ADC_BITS-1:0] raw_reg;
    logic [14:0]         sp_reg;
    logic                open_hit_reg, close_hit_reg;

    // working registers
    logic [ADC_BITS-1:0]     den_reg, rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic signed [15:0]      pos_reg, err_reg, prev_reg;
    logic signed [IB-1:0]    integ_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [7:0]       speed_reg;
    logic                    m_tvalid_reg;
    logic [vpmd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // combinational helpers
    logic signed [SPAN_W-1:0] diff_raw, span;
    logic [SPAN_W-1:0]        span_abs;
    logic signed [PW-1:0]     prod_abs;
    logic [ADC_BITS:0]        trial, trial_sub;
    logic                     trial_ge;
    logic [NUM_W-1:0]         q_clamped;
    logic signed [16:0]       err_wide, err_mag, err_delta;
    logic signed [15:0]       err_sat;
    logic signed [IB:0]       integ_sum;
    logic signed [IB-1:0]     integ_sat;
    logic                     integ_clear;
    logic signed [ACC_W-1:0]  acc_adj, acc_q;
    logic signed [7:0]        speed_clamped;
    logic [6:0]               speed_mag;
    logic [15:0]              duty_base;
    logic                     drive_stop;
    logic [1:0]               dir_out;
    logic [7:0]               duty_out;
    logic signed [15:0]       mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PW-1:0]     mul_p;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // calibration offsets
    always_comb begin
        diff_raw = $signed({1'b0, raw_reg}) - $signed({1'b0, close_reg});
        span     = $signed({1'b0, open_reg}) - $signed({1'b0, close_reg});
        span_abs = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
        prod_abs = prod_reg[PW-1] ? -prod_reg : prod_reg;
    end

    // restoring divider step, one quotient bit
    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_ge  = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
        q_clamped = (num_reg > NUM_W'(vpmd_pkg::POS_LIMIT_Q)) ?
                    NUM_W'(vpmd_pkg::POS_LIMIT_Q) : num_reg;
    end

    // error, deadband and integral update
    always_comb begin
        err_wide = $signed({2'b00, sp_reg}) - 17'(pos_reg);
        if (err_wide > 17'sd32767) begin
            err_sat = 16'sh7fff;
        end else if (err_wide < -17'sd32768) begin
            err_sat = 16'sh8000;
        end else begin
            err_sat = err_wide[15:0];
        end
        err_mag   = err_reg[15] ? -17'(err_reg) : 17'(err_reg);
        err_delta = 17'(err_reg) - 17'(prev_reg);
        integ_sum = (IB+1)'(integ_reg) + (IB+1)'(err_reg);
        if (integ_sum[IB] != integ_sum[IB-1]) begin
            integ_sat = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[IB-1:0];
        end
        integ_clear = (err_mag > 17'(vpmd_pkg::RESET_Q)) ||
                      (prev_reg < 0 && err_reg > 0) ||
                      (prev_reg > 0 && err_reg < 0);
    end

    // truncate q16.16 sum toward zero and clamp speed
    always_comb begin
        acc_adj = acc_reg[ACC_W-1] ? (acc_reg + ACC_W'(65535)) : acc_reg;
        acc_q   = acc_adj >>> 16;
        if (acc_q > ACC_W'(vpmd_pkg::SPEED_MAX)) begin
            speed_clamped = 8'(vpmd_pkg::SPEED_MAX);
        end else if (acc_q < -ACC_W'(vpmd_pkg::SPEED_MAX)) begin
            speed_clamped = -8'(vpmd_pkg::SPEED_MAX);
        end else begin
            speed_clamped = acc_q[7:0];
        end
    end

    // direction and duty
    always_comb begin
        speed_mag  = speed_reg[7] ? 7'(-speed_reg) : speed_reg[6:0];
        duty_base  = {1'b0, speed_mag, 8'h00} - {9'h000, speed_mag};
        drive_stop = (open_hit_reg && sp_reg > 15'(vpmd_pkg::OPEN_END_Q)) ||
                     (close_hit_reg && sp_reg <= 15'(vpmd_pkg::CLOSE_END_Q)) ||
                     (speed_reg == 8'sd0);
        if (drive_stop) begin
            dir_out  = vpmd_pkg::DIR_STOP;
            duty_out = 8'h00;
        end else begin
            dir_out  = speed_reg[7] ? vpmd_pkg::DIR_CLOSE : vpmd_pkg::DIR_OPEN;
            duty_out = prod_reg[vpmd_pkg::DUTY_SHIFT+7:vpmd_pkg::DUTY_SHIFT];
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_MPOS: begin
                mul_a = 16'(vpmd_pkg::FULL_SCALE_Q);
                mul_b = MB_W'(diff_raw);
            end
            ST_MP: begin
                mul_a = gain_p_reg;
                mul_b = MB_W'(err_reg);
            end
            ST_MI: begin
                mul_a = ki_ts_reg;
                mul_b = MB_W'(integ_reg);
            end
            ST_MD: begin
                mul_a = kd_reg;
                mul_b = MB_W'(err_delta);
            end
            ST_MDUTY: begin
                mul_a = 16'(vpmd_pkg::DUTY_RECIP);
                mul_b = MB_W'($signed(duty_base));
            end
            default: begin
                mul_a = 16'sd0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // sequencer, configuration and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            close_reg    <= '0;
            open_reg     <= ADC_BITS'(1023);
            gain_p_reg   <= '0;
            ki_ts_reg    <= '0;
            kd_reg       <= '0;
            integ_reg    <= '0;
            prev_reg     <= '0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    vpmd_pkg::REG_CLOSE_POS: close_reg  <= cfg_wdata[ADC_BITS-1:0];
                    vpmd_pkg::REG_OPEN_POS:  open_reg   <= cfg_wdata[ADC_BITS-1:0];
                    vpmd_pkg::REG_GAIN_P:    gain_p_reg <= $signed(cfg_wdata);
                    vpmd_pkg::REG_KI_TS:     ki_ts_reg  <= $signed(cfg_wdata);
                    vpmd_pkg::REG_KD_OVER:   kd_reg     <= $signed(cfg_wdata);
                    default: ;
                endcase
            end

            // result handoff, the final state loads the output itself
            if (m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        raw_reg       <= s_tdata[ADC_BITS-1:0];
                        sp_reg        <= s_tdata[ADC_BITS+14:ADC_BITS];
                        open_hit_reg  <= s_tdata[ADC_BITS+15];
                        close_hit_reg <= s_tdata[ADC_BITS+16];
                        state_reg     <= ST_MPOS;
                    end
                end
                ST_MPOS: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DIVSET;
                end
                ST_DIVSET: begin
                    if (span == '0) begin
                        pos_reg   <= '0;
                        state_reg <= ST_ERR;
                    end else begin
                        num_reg   <= prod_abs[NUM_W-1:0];
                        den_reg   <= span_abs[ADC_BITS-1:0];
                        neg_reg   <= prod_reg[PW-1] ^ span[SPAN_W-1];
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(NUM_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS: begin
                    pos_reg   <= neg_reg ? -$signed(q_clamped[15:0]) : $signed(q_clamped[15:0]);
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    err_reg   <= err_sat;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (err_mag < 17'(vpmd_pkg::DEADBAND_Q)) begin
                        speed_reg <= 8'sd0;
                        prev_reg  <= err_reg;
                        state_reg <= ST_MDUTY;
                    end else begin
                        integ_reg <= integ_clear ? '0 : integ_sat;
                        state_reg <= ST_MP;
                    end
                end
                ST_MP: begin
                    prod_reg  <= mul_p;
                    acc_reg   <= '0;
                    state_reg <= ST_MI;
                end
                ST_MI: begin
                    prod_reg  <= mul_p;
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= ST_MD;
                end
                ST_MD: begin
                    prod_reg  <= mul_p;
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= ST_SPD;
                end
                ST_SPD: begin
                    speed_reg <= speed_clamped;
                    prev_reg  <= err_reg;
                    state_reg <= ST_MDUTY;
                end
                ST_MDUTY: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // wait until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b000000, pos_reg, duty_out, dir_out};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/vpmd_checker.sv
// port checker for the valve pid motor drive core, with its bind
module vpmd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vpmd_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no second request taken right after one is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // direction code is always a defined one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == vpmd_pkg::DIR_STOP ||
                      m_tdata[1:0] == vpmd_pkg::DIR_OPEN ||
                      m_tdata[1:0] == vpmd_pkg::DIR_CLOSE))
        else $error("undefined drive direction");

    // a stopped drive has zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == vpmd_pkg::DIR_STOP |-> m_tdata[9:2] == 8'h00)
        else $error("duty nonzero while stopped");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind valve_pid_motor_drive_core vpmd_checker u_vpmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
